// ===== src/binary_to_decimal_ascii_128_defines.svh =====
// Assertion macros shared by the converter's checker.
// No dependencies; include guard below.
`ifndef BINARY_TO_DECIMAL_ASCII_128_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_128_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define B2D_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define B2D_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/b2d_pkg.sv =====
// Types and constants of the 128-bit binary to decimal ASCII converter.
// No dependencies.
package b2d_pkg;

  localparam int BIN_W      = 128;
  localparam int NUM_DIGITS = 39;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int SHIFT_CNT_W = $clog2(BIN_W);
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  typedef logic [BCD_W-1:0] bcd_word_t;

  // Input beat
  typedef struct packed {
    logic [63:0] value_high;
    logic [63:0] value_low;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [5:0] digit_char;
    logic       last_char;
  } out_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/b2d_front.sv =====
// Front end: accepts a 128-bit value and runs shift-and-add-3, one bit a cycle.
// Depends on b2d_pkg.
module b2d_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  b2d_pkg::in_t        in_data,
  input  b2d_pkg::q_status_t  q_status,
  output logic                push,
  output b2d_pkg::bcd_word_t  push_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t                               state_r, state_nxt;
  logic [b2d_pkg::BIN_W-1:0]            bin_r, bin_nxt;
  b2d_pkg::bcd_word_t                   bcd_r, bcd_nxt;
  logic [b2d_pkg::SHIFT_CNT_W-1:0]      cnt_r, cnt_nxt;
  b2d_pkg::bcd_word_t                   bcd_adj;
  logic                                 accept;

  // Add 3 to every digit of 5 or more, all digits in parallel
  always_comb begin
    for (int d = 0; d < b2d_pkg::NUM_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  // Ready when idle, or when the finished word leaves this cycle
  assign push      = (state_r == ST_DONE) && !q_status.full;
  assign busy      = !((state_r == ST_IDLE) || push);
  assign accept    = start && !busy;
  assign push_data = bcd_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_RUN: begin
        {bcd_nxt, bin_nxt} = {bcd_adj[b2d_pkg::BCD_W-2:0], bin_r, 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == {b2d_pkg::SHIFT_CNT_W{1'b1}}) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
      end
    endcase
    if (accept) begin
      state_nxt = ST_RUN;
      bin_nxt   = {in_data.value_high, in_data.value_low};
      bcd_nxt   = '0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

endmodule

// ===== src/b2d_queue.sv =====
// Two-entry queue of converted BCD words between front and back.
// Depends on b2d_pkg.
module b2d_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b2d_pkg::bcd_word_t  push_data,
  input  logic                pop,
  output b2d_pkg::bcd_word_t  pop_data,
  output b2d_pkg::q_status_t  status
);

  b2d_pkg::bcd_word_t mem_r [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         count_r;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/b2d_back.sv =====
// Back end: walks a BCD word top digit first, skips leading zeros, emits ASCII.
// Depends on b2d_pkg.
module b2d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  b2d_pkg::q_status_t  q_status,
  input  b2d_pkg::bcd_word_t  pop_data,
  output logic                pop,
  output logic                out_strobe,
  output b2d_pkg::out_t       out_data
);

  localparam logic [b2d_pkg::DIGIT_IDX_W-1:0] LAST_IDX =
    b2d_pkg::DIGIT_IDX_W'(b2d_pkg::NUM_DIGITS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t                           state_r, state_nxt;
  b2d_pkg::bcd_word_t               sh_r, sh_nxt;
  logic [b2d_pkg::DIGIT_IDX_W-1:0]  idx_r, idx_nxt;
  logic                             started_r, started_nxt;
  logic                             strobe_r, strobe_nxt;
  b2d_pkg::out_t                    data_r, data_nxt;
  logic [3:0]                       top;
  logic                             at_last;
  logic                             emit;

  assign top     = sh_r[b2d_pkg::BCD_W-1 -: 4];
  assign at_last = (idx_r == LAST_IDX);
  assign emit    = started_r || (top != 4'd0) || at_last;
  // Take the next word when idle or on the final digit of the current one
  assign pop     = !q_status.empty && ((state_r == ST_IDLE) || at_last);

  always_comb begin
    state_nxt   = state_r;
    sh_nxt      = sh_r;
    idx_nxt     = idx_r;
    started_nxt = started_r;
    strobe_nxt  = 1'b0;
    data_nxt    = data_r;
    unique case (state_r)
      ST_EMIT: begin
        strobe_nxt          = emit;
        data_nxt.digit_char = b2d_pkg::ASCII_ZERO + {2'b00, top};
        data_nxt.last_char  = at_last;
        sh_nxt      = {sh_r[b2d_pkg::BCD_W-5:0], 4'd0};
        idx_nxt     = idx_r + 1'b1;
        started_nxt = emit;
        if (at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
      end
    endcase
    if (pop) begin
      state_nxt   = ST_EMIT;
      sh_nxt      = pop_data;
      idx_nxt     = '0;
      started_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      started_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      started_r <= started_nxt;
      strobe_r  <= strobe_nxt;
    end
    sh_r   <= sh_nxt;
    data_r <= data_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = data_r;

endmodule

// ===== src/binary_to_decimal_ascii_128.sv =====
// 128-bit binary to decimal ASCII converter, top level.
// The front shifts one bit a cycle; it stays busy until its word is queued.
// Each word goes via the queue to the back, which walks all 39 digits in turn.
// The back emits one character a cycle from the first nonzero or last digit on.
// Synchronous active-low reset empties the queue and idles both ends.
// Results cannot be stalled; each strobe lasts one cycle.
module binary_to_decimal_ascii_128 (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  b2d_pkg::in_t   in_data,
  output logic           out_strobe,
  output b2d_pkg::out_t  out_data
);

  b2d_pkg::q_status_t q_status;
  b2d_pkg::bcd_word_t push_data;
  b2d_pkg::bcd_word_t pop_data;
  logic               push;
  logic               pop;

  b2d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  b2d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  b2d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// ===== src/b2d_checker.sv =====
// Port-level checker for the converter, bound to the top level.
// Depends on b2d_pkg and binary_to_decimal_ascii_128_defines.svh.
`include "binary_to_decimal_ascii_128_defines.svh"

module b2d_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_strobe,
  input b2d_pkg::out_t  out_data
);

  logic in_beat;
  assign in_beat = start && !busy;

  // Every character is a decimal digit
  `B2D_ASSERT_IMP(a_digit_range, clk, rst_n, out_strobe, (out_data.digit_char >= 6'd48) && (out_data.digit_char <= 6'd57), "digit out of range")

  // Converter turns busy right after a beat
  `B2D_ASSERT_NXT(a_busy_after_beat, clk, rst_n, in_beat, busy, "not busy after beat")

  // Still busy on the last shift cycle
  `B2D_ASSERT_NXT(a_busy_full_run, clk, rst_n, in_beat, ##127 busy, "run ended early")

endmodule

bind binary_to_decimal_ascii_128 b2d_checker u_b2d_checker (.*);
